/* design/rgd_pkg.sv */
// ----------------------------------------------------------------------------
// rgd_pkg
// Shared types and constants of the grid ray caster.
// ----------------------------------------------------------------------------
`default_nettype none
package rgd_pkg;

  localparam int unsigned MapSide      = 64;
  localparam int unsigned MapBits      = $clog2(MapSide);
  localparam int unsigned ScreenWidth  = 1024;
  localparam int unsigned ScreenHeight = 768;

  localparam logic OpWrite = 1'b0;
  localparam logic OpCast  = 1'b1;

  localparam logic [0:0] CfgMapColumns = 1'b0;
  localparam logic [0:0] CfgMapRows    = 1'b1;

  typedef struct packed {
    logic        op;
    logic [5:0]  cell_col;
    logic [5:0]  cell_row;
    logic        cell_is_wall;
    logic [13:0] player_x;
    logic [13:0] player_y;
    logic [15:0] ray_dir_x;
    logic [15:0] ray_dir_y;
    logic [9:0]  screen_col;
  } item_t;

  typedef struct packed {
    logic [9:0]  column_out;
    logic [9:0]  span_top;
    logic [9:0]  span_end;
    logic        hit_side;
    logic [15:0] perp_distance;
    logic        left_map;
  } result_t;

endpackage
`default_nettype wire

/* design/rgd_item_if.sv */
// ----------------------------------------------------------------------------
// rgd_item_if
// Valid/ready channel carrying one input item.
// ----------------------------------------------------------------------------
`default_nettype none
interface rgd_item_if;
  logic          valid;
  logic          ready;
  rgd_pkg::item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

/* design/rgd_result_if.sv */
// ----------------------------------------------------------------------------
// rgd_result_if
// Valid/ready channel carrying one result item.
// ----------------------------------------------------------------------------
`default_nettype none
interface rgd_result_if;
  logic            valid;
  logic            ready;
  rgd_pkg::result_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

/* design/rgd_front.sv */
// ----------------------------------------------------------------------------
// rgd_front
// Two-entry queue that decouples item intake from the ray walker.
// ----------------------------------------------------------------------------
`default_nettype none
module rgd_front (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  output logic                 in_ready_o,
  input  wire rgd_pkg::item_t  in_data_i,
  output logic                 q_valid_o,
  input  wire logic            q_pop_i,
  output rgd_pkg::item_t       q_data_o
);
  rgd_pkg::item_t mem_q [2];
  logic wr_q, rd_q;
  logic [1:0] cnt_q;
  logic push;

  assign in_ready_o = (cnt_q != 2'd2);
  assign push       = in_valid_i && in_ready_o;
  assign q_valid_o  = (cnt_q != 2'd0);
  assign q_data_o   = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_q] <= in_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q <= 1'b0; rd_q <= 1'b0; cnt_q <= 2'd0;
    end else begin
      if (push) wr_q <= ~wr_q;
      if (q_pop_i) rd_q <= ~rd_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, q_pop_i};
    end
  end
endmodule
`default_nettype wire

/* design/rgd_div.sv */
// ----------------------------------------------------------------------------
// rgd_div
// Restoring divider, one quotient bit per cycle, 41-bit dividend.
// ----------------------------------------------------------------------------
`default_nettype none
module rgd_div (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  input  wire logic [40:0] num_i,
  input  wire logic [16:0] den_i,
  output logic             busy_o,
  output logic [40:0]      quo_o
);
  logic [40:0] quo_q;
  logic [16:0] rem_q;
  logic [16:0] den_q;
  logic [5:0]  cnt_q;
  logic [17:0] trial;

  assign trial  = {rem_q, quo_q[40]} - {1'b0, den_q};
  assign busy_o = (cnt_q != 6'd0);
  assign quo_o  = quo_q;

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= num_i; rem_q <= '0; den_q <= den_i;
    end else if (busy_o) begin
      if (!trial[17]) begin
        rem_q <= trial[16:0];
        quo_q <= {quo_q[39:0], 1'b1};
      end else begin
        rem_q <= {rem_q[15:0], quo_q[40]};
        quo_q <= {quo_q[39:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) cnt_q <= 6'd0;
    else if (start_i) cnt_q <= 6'd41;
    else if (busy_o) cnt_q <= cnt_q - 6'd1;
  end
endmodule
`default_nettype wire

/* design/rgd_back.sv */
// ----------------------------------------------------------------------------
// rgd_back
// Map store, step lengths, DDA walk, distance and span, output register.
// ----------------------------------------------------------------------------
`default_nettype none
module rgd_back (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             q_valid_i,
  output logic                  q_pop_o,
  input  wire rgd_pkg::item_t   q_data_i,
  input  wire logic [6:0]       cols_i,
  input  wire logic [6:0]       rows_i,
  output logic                  out_valid_o,
  input  wire logic             out_ready_i,
  output rgd_pkg::result_t      out_data_o
);
  localparam logic [3:0] SIdle = 4'd0, SDivX = 4'd1, SWaitX = 4'd2, SDivY = 4'd3,
    SWaitY = 4'd4, SInitX = 4'd5, SInitY = 4'd6, SStep = 4'd7, SRead = 4'd8,
    SPerp = 4'd9, SDivH = 4'd10, SWaitH = 4'd11, SSpan = 4'd12, SOut = 4'd13;
  localparam int unsigned AddrBits = 2 * rgd_pkg::MapBits;
  localparam logic [9:0] Height = 10'(rgd_pkg::ScreenHeight);

  logic [3:0] st_q;
  logic map_q [rgd_pkg::MapSide * rgd_pkg::MapSide];
  logic rd_bit_q;
  rgd_pkg::item_t it_q;
  logic [40:0] dx_q, dy_q;
  logic [63:0] sx_q, sy_q;
  logic [8:0] cx_q, cy_q;
  logic side_q, left_q;
  logic [15:0] perp_q;
  logic [9:0] top_q, end_q;
  rgd_pkg::result_t res_q;
  logic res_v_q;

  logic div_start, div_busy;
  logic [40:0] div_num, div_quo;
  logic [16:0] div_den;

  rgd_div u_div (.clk_i, .rst_ni, .start_i(div_start), .num_i(div_num),
                 .den_i(div_den), .busy_o(div_busy), .quo_o(div_quo));

  function automatic logic [16:0] mag16(input logic [15:0] v);
    mag16 = v[15] ? (17'h10000 - {1'b0, v}) : {1'b0, v};
  endfunction

  logic [16:0] magx, magy;
  logic [6:0] lim_c, lim_r;
  logic [8:0] ncx, ncy;
  logic step_x, out_c;
  logic [63:0] pdiff;
  logic [39:0] pshift;

  assign magx   = mag16(it_q.ray_dir_x);
  assign magy   = mag16(it_q.ray_dir_y);
  assign lim_c  = (cols_i > 7'(rgd_pkg::MapSide)) ? 7'(rgd_pkg::MapSide) : cols_i;
  assign lim_r  = (rows_i > 7'(rgd_pkg::MapSide)) ? 7'(rgd_pkg::MapSide) : rows_i;
  assign step_x = (sx_q < sy_q);
  assign ncx    = step_x ? (it_q.ray_dir_x[15] ? cx_q - 9'd1 : cx_q + 9'd1) : cx_q;
  assign ncy    = step_x ? cy_q : (it_q.ray_dir_y[15] ? cy_q - 9'd1 : cy_q + 9'd1);
  assign out_c  = ncx[8] || ncy[8] || (ncx[7:0] >= {1'b0, lim_c})
                  || (ncy[7:0] >= {1'b0, lim_r});
  assign pdiff  = side_q ? (sy_q - {15'd0, dy_q, 8'd0}) : (sx_q - {15'd0, dx_q, 8'd0});
  assign pshift = pdiff[63:24];

  assign div_start = (st_q == SDivX) || (st_q == SDivY) || (st_q == SDivH);
  always_comb begin
    div_num = 41'd1 << 38;
    div_den = magx;
    if (st_q == SDivY) div_den = magy;
    if (st_q == SDivH) begin
      div_num = 41'((rgd_pkg::ScreenWidth / 2) * 256);
      div_den = {1'b0, perp_q};
    end
  end

  assign q_pop_o     = q_valid_i && (st_q == SIdle);
  assign out_valid_o = res_v_q;
  assign out_data_o  = res_q;

  // Map write port and registered read port. The read address is the cell
  // being entered, so the bit is ready in the cycle after the step.
  always_ff @(posedge clk_i) begin
    if (q_pop_o && q_data_i.op == rgd_pkg::OpWrite)
      map_q[{q_data_i.cell_row, q_data_i.cell_col}] <= q_data_i.cell_is_wall;
    rd_bit_q <= map_q[AddrBits'({ncy[5:0], ncx[5:0]})];
  end

  always_ff @(posedge clk_i) begin
    unique case (st_q)
      SIdle: if (q_pop_o) begin
        it_q <= q_data_i;
        cx_q <= {3'd0, q_data_i.player_x[13:8]};
        cy_q <= {3'd0, q_data_i.player_y[13:8]};
      end
      SWaitX: if (!div_busy) dx_q <= (magx == 17'd0) ? (41'd1 << 40) : div_quo;
      SWaitY: if (!div_busy) dy_q <= (magy == 17'd0) ? (41'd1 << 40) : div_quo;
      SInitX: sx_q <= 64'(dx_q) * 64'(it_q.ray_dir_x[15] ? {1'b0, it_q.player_x[7:0]}
                       : 9'd256 - {1'b0, it_q.player_x[7:0]});
      SInitY: sy_q <= 64'(dy_q) * 64'(it_q.ray_dir_y[15] ? {1'b0, it_q.player_y[7:0]}
                       : 9'd256 - {1'b0, it_q.player_y[7:0]});
      SStep: begin
        if (step_x) sx_q <= sx_q + {15'd0, dx_q, 8'd0};
        else sy_q <= sy_q + {15'd0, dy_q, 8'd0};
        cx_q <= ncx; cy_q <= ncy; side_q <= !step_x; left_q <= out_c;
      end
      SPerp: perp_q <= (pshift > 40'd65535) ? 16'hFFFF : pshift[15:0];
      SWaitH: if (!div_busy) begin
        if (perp_q == 16'd0 || div_quo >= 41'(rgd_pkg::ScreenHeight)) begin
          top_q <= 10'd0; end_q <= Height;
        end else begin
          top_q <= 10'((Height - div_quo[9:0]) >> 1);
          end_q <= 10'((Height - div_quo[9:0]) >> 1) + div_quo[9:0];
        end
      end
      SSpan: if (!res_v_q || out_ready_i) begin
        res_q <= '{column_out: it_q.screen_col, span_top: top_q, span_end: end_q,
                   hit_side: side_q, perp_distance: perp_q, left_map: left_q};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= SIdle; res_v_q <= 1'b0;
    end else begin
      if (st_q == SSpan && (!res_v_q || out_ready_i)) res_v_q <= 1'b1;
      else if (out_ready_i) res_v_q <= 1'b0;
      unique case (st_q)
        SIdle:  if (q_pop_o && q_data_i.op == rgd_pkg::OpCast) st_q <= SDivX;
        SDivX:  st_q <= SWaitX;
        SWaitX: if (!div_busy) st_q <= SDivY;
        SDivY:  st_q <= SWaitY;
        SWaitY: if (!div_busy) st_q <= SInitX;
        SInitX: st_q <= SInitY;
        SInitY: st_q <= SStep;
        SStep:  st_q <= out_c ? SPerp : SRead;
        SRead:  st_q <= rd_bit_q ? SPerp : SStep;
        SPerp:  st_q <= SDivH;
        SDivH:  st_q <= SWaitH;
        SWaitH: if (!div_busy) st_q <= SSpan;
        SSpan:  if (!res_v_q || out_ready_i) st_q <= SIdle;
        default: st_q <= SIdle;
      endcase
    end
  end
endmodule
`default_nettype wire

/* design/ray_grid_dda_column.sv */
// ----------------------------------------------------------------------------
// ray_grid_dda_column
// Grid ray caster: map loading and one DDA cast per screen column.
// ----------------------------------------------------------------------------
// Channel   Dir  Beat contents
// item      in   op, map cell write fields, cast fields (position, ray, column)
// result    out  column, span, hit side, distance, left-map flag (casts only)
// cfg       in   cfg_we_i, cfg_idx_i, cfg_data_i (map_columns, map_rows)
//
// A write beat is taken in the idle state and leaves the walker idle. A cast
// runs three 41-step serial divisions (two step lengths, one span height) and
// their setup, then a step state and a read state for each map cell walked,
// bar the read for the cell that leaves the map, as each map read is registered.
// Reset clears control state and sets the map size to 64 by 64; the map
// itself is undefined until written. A two-beat queue lets intake continue
// while the walker works, and a result register holds a beat under stall.
`default_nettype none
module ray_grid_dda_column (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  rgd_item_if.sink        item_i,
  rgd_result_if.source    result_o,
  input  wire logic       cfg_we_i,
  input  wire logic [0:0] cfg_idx_i,
  input  wire logic [6:0] cfg_data_i
);
  logic [6:0] cols_q, rows_q;
  logic q_valid, q_pop;
  rgd_pkg::item_t q_data;

  // Configuration registers: user writes only while idle; block does not enforce.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cols_q <= 7'd64; rows_q <= 7'd64;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        rgd_pkg::CfgMapColumns: cols_q <= cfg_data_i;
        rgd_pkg::CfgMapRows:    rows_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  rgd_front u_front (.clk_i, .rst_ni, .in_valid_i(item_i.valid),
    .in_ready_o(item_i.ready), .in_data_i(item_i.data), .q_valid_o(q_valid),
    .q_pop_i(q_pop), .q_data_o(q_data));

  rgd_back u_back (.clk_i, .rst_ni, .q_valid_i(q_valid), .q_pop_o(q_pop),
    .q_data_i(q_data), .cols_i(cols_q), .rows_i(rows_q),
    .out_valid_o(result_o.valid), .out_ready_i(result_o.ready),
    .out_data_o(result_o.data));

  // A popped beat must have been in the queue.
  a_pop_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> q_valid) else $error("pop from empty queue");
  // A result held under stall keeps its value.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_o.valid && !result_o.ready |=> $stable(result_o.data))
    else $error("result changed under stall");
  // Span end never passes the screen height.
  a_span: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_o.valid |-> result_o.data.span_end <= 10'(rgd_pkg::ScreenHeight))
    else $error("span beyond screen");
endmodule
`default_nettype wire

/* bench/rgd_column_checker.sv */
// ----------------------------------------------------------------------------
// rgd_column_checker
// Watches the item, result and register ports of the grid ray caster. It
// keeps its own wall map and map size, works out each cast's column result
// and compares the result beats in order.
// ----------------------------------------------------------------------------
module rgd_column_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  rgd_item_if         item_i,
  rgd_result_if       result_i,
  input  logic        cfg_we_i,
  input  logic [0:0]  cfg_idx_i,
  input  logic [6:0]  cfg_data_i,
  output int unsigned fail_count_o,
  output int unsigned pending_o,
  output int unsigned columns_checked_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [63:0] StepZero = 64'd1 << 40;

  bit                wall_map [rgd_pkg::MapSide*rgd_pkg::MapSide];
  logic [6:0]        map_columns;
  logic [6:0]        map_rows;
  rgd_pkg::result_t  expected_columns [$];

  // Step length per axis: 1/|dir| in Q.24, with a zero component given the
  // largest length of all.
  function automatic logic [63:0] axis_step(input logic [15:0] dir, output bit neg);
    logic [63:0] mag;
    neg = dir[15];
    mag = neg ? 64'(17'h10000 - {1'b0, dir}) : 64'(dir);
    if (mag == 0) return StepZero;
    return (64'd1 << 38) / mag;
  endfunction

  function automatic rgd_pkg::result_t cast_column(input rgd_pkg::item_t it);
    rgd_pkg::result_t res;
    bit          negx, negy, left_map, side;
    logic [63:0] dx, dy, sx, sy, ax, ay, perp, h;
    int          cx, cy, cols, rows;
    dx = axis_step(it.ray_dir_x, negx);
    dy = axis_step(it.ray_dir_y, negy);
    sx = (negx ? 64'(it.player_x[7:0]) : 64'(256 - it.player_x[7:0])) * dx;
    sy = (negy ? 64'(it.player_y[7:0]) : 64'(256 - it.player_y[7:0])) * dy;
    ax = dx << 8;
    ay = dy << 8;
    cx = int'(it.player_x[13:8]);
    cy = int'(it.player_y[13:8]);
    cols = (map_columns > rgd_pkg::MapSide) ? rgd_pkg::MapSide : int'(map_columns);
    rows = (map_rows > rgd_pkg::MapSide) ? rgd_pkg::MapSide : int'(map_rows);
    left_map = 1'b0;
    side = 1'b0;
    forever begin
      // The strictly nearer boundary wins; a tie steps along y.
      if (sx < sy) begin
        sx += ax;
        cx += negx ? -1 : 1;
        side = 1'b0;
      end else begin
        sy += ay;
        cy += negy ? -1 : 1;
        side = 1'b1;
      end
      if (cx < 0 || cy < 0 || cx >= cols || cy >= rows) begin
        left_map = 1'b1;
        break;
      end
      if (wall_map[cy*rgd_pkg::MapSide + cx]) break;
    end
    perp = (side ? (sy - ay) : (sx - ax)) >> 24;
    if (perp > 64'hFFFF) perp = 64'hFFFF;
    res.column_out    = it.screen_col;
    res.hit_side      = side;
    res.perp_distance = perp[15:0];
    res.left_map      = left_map;
    if (perp == 0) begin
      res.span_top = '0;
      res.span_end = 10'(rgd_pkg::ScreenHeight);
    end else begin
      h = 64'(rgd_pkg::ScreenWidth / 2 * 256) / perp;
      if (h >= rgd_pkg::ScreenHeight) begin
        res.span_top = '0;
        res.span_end = 10'(rgd_pkg::ScreenHeight);
      end else begin
        res.span_top = 10'((rgd_pkg::ScreenHeight - h) >> 1);
        res.span_end = 10'(((rgd_pkg::ScreenHeight - h) >> 1) + h);
      end
    end
    return res;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("%0t: column mismatch on %s: got %0d, want %0d", $time, what, got, want);
    fail_count_o++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    rgd_pkg::result_t got, want;
    if (!rst_ni) begin
      foreach (wall_map[i]) wall_map[i] = 1'b0;
      map_columns = 7'd64;
      map_rows = 7'd64;
      expected_columns.delete();
      fail_count_o = 0;
      columns_checked_o = 0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == rgd_pkg::CfgMapColumns) map_columns = cfg_data_i;
        else map_rows = cfg_data_i;
      end
      if (item_i.valid && item_i.ready) begin
        if (item_i.data.op == rgd_pkg::OpWrite)
          wall_map[item_i.data.cell_row*rgd_pkg::MapSide + item_i.data.cell_col] =
            item_i.data.cell_is_wall;
        else
          expected_columns.push_back(cast_column(item_i.data));
      end
      if (result_i.valid && result_i.ready) begin
        got = result_i.data;
        if (expected_columns.size() == 0) begin
          $display("%0t: result beat for column %0d with none expected", $time,
                   got.column_out);
          fail_count_o++;
        end else begin
          want = expected_columns.pop_front();
          columns_checked_o++;
          if (got.column_out != want.column_out)
            report_mismatch("column_out", got.column_out, want.column_out);
          if (got.span_top != want.span_top)
            report_mismatch("span_top", got.span_top, want.span_top);
          if (got.span_end != want.span_end)
            report_mismatch("span_end", got.span_end, want.span_end);
          if (got.hit_side != want.hit_side)
            report_mismatch("hit_side", got.hit_side, want.hit_side);
          if (got.perp_distance != want.perp_distance)
            report_mismatch("perp_distance", got.perp_distance, want.perp_distance);
          if (got.left_map != want.left_map)
            report_mismatch("left_map", got.left_map, want.left_map);
        end
      end
    end
    pending_o = expected_columns.size();
  end

endmodule

/* bench/tb_ray_grid_dda_column.sv */
// ----------------------------------------------------------------------------
// tb_ray_grid_dda_column
// Stimulus and verdict for the grid ray caster. A square region of the map,
// closed by a wall row and column on its far sides, is loaded in full, then
// directed casts hit the field extremes and special directions, and phases
// of random casts and cell rewrites run under several map sizes.
// ----------------------------------------------------------------------------
module tb_ray_grid_dda_column;
  timeunit 1ns;
  timeprecision 1ps;

  // Side of the loaded region. Its last row and column are walls, so a ray
  // that starts inside never reaches a cell beyond it, whatever the map size.
  localparam int Region = 24;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [0:0]  cfg_idx_i;
  logic [6:0]  cfg_data_i;
  int unsigned fail_count;
  int unsigned pending;
  int unsigned columns_checked;
  int unsigned casts_sent;
  int unsigned writes_sent;
  bit          no_idle;
  int          stall_left;
  int          last_cols;
  int          last_rows;

  rgd_item_if   item_ch ();
  rgd_result_if result_ch ();

  ray_grid_dda_column dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .item_i     (item_ch),
    .result_o   (result_ch),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  rgd_column_checker checker_u (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .item_i            (item_ch),
    .result_i          (result_ch),
    .cfg_we_i          (cfg_we_i),
    .cfg_idx_i         (cfg_idx_i),
    .cfg_data_i        (cfg_data_i),
    .fail_count_o      (fail_count),
    .pending_o         (pending),
    .columns_checked_o (columns_checked)
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // Mostly no gap, often a short one, now and then a long one. During
  // no-idle phases both sides run flat out.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 40);
  endfunction

  // The result side stalls with the same kind of gap pattern.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      result_ch.ready <= 1'b0;
      stall_left = 0;
    end else if (stall_left > 0) begin
      stall_left--;
      result_ch.ready <= 1'b0;
    end else begin
      stall_left = pick_gap();
      result_ch.ready <= (stall_left == 0);
    end
  end

  // Presents one beat after a random gap and returns once it is accepted.
  // With no gap, valid simply stays high and the payload changes, so valid
  // gets a single assignment in that time step.
  task automatic send_beat(input rgd_pkg::item_t it);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      item_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    item_ch.valid <= 1'b1;
    item_ch.data <= it;
    @(posedge clk_i);
    while (!item_ch.ready) @(posedge clk_i);
    if (it.op == rgd_pkg::OpCast) casts_sent++;
    else writes_sent++;
  endtask

  // A write beat carries random cast fields too; the block should ignore them.
  task automatic write_cell(input int col, input int row, input bit wall);
    rgd_pkg::item_t it;
    it = rgd_pkg::item_t'({$urandom, $urandom, $urandom});
    it.op = rgd_pkg::OpWrite;
    it.cell_col = 6'(col);
    it.cell_row = 6'(row);
    it.cell_is_wall = wall;
    send_beat(it);
  endtask

  task automatic cast_ray(input int px, input int py, input int dirx, input int diry,
                          input int col);
    rgd_pkg::item_t it;
    it = rgd_pkg::item_t'({$urandom, $urandom, $urandom});
    it.op = rgd_pkg::OpCast;
    it.player_x = 14'(px);
    it.player_y = 14'(py);
    it.ray_dir_x = 16'(dirx);
    it.ray_dir_y = 16'(diry);
    it.screen_col = 10'(col);
    send_beat(it);
  endtask

  // Registers change only with the block idle: no column is outstanding and
  // any trailing cell write has had time to land.
  task automatic set_map_size(input int cols, input int rows);
    item_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= rgd_pkg::CfgMapColumns;
    cfg_data_i <= 7'(cols);
    @(posedge clk_i);
    cfg_idx_i <= rgd_pkg::CfgMapRows;
    cfg_data_i <= 7'(rows);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    last_cols = cols;
    last_rows = rows;
  endtask

  // Random direction: mostly unit length at a random angle, some raw 16-bit
  // values, some zero, unit or full-scale components.
  function automatic int rand_dir(input bit want_x, input real ang);
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $rtoi(16384.0 * (want_x ? $cos(ang) : $sin(ang)));
    if (r < 85) return int'($signed(16'($urandom)));
    case ($urandom_range(0, 4))
      0: return 0;
      1: return 16384;
      2: return -16384;
      3: return -32768;
      default: return 32767;
    endcase
  endfunction

  // One random phase under the current map size: mostly casts, some rewrites
  // of cells inside the walled region. When the map reaches past the loaded
  // region, every cast starts inside the walls; otherwise some start anywhere.
  task automatic random_phase(input int beats);
    real ang;
    int  px, py, span_x, span_y;
    bit  far_ok;
    far_ok = (last_cols <= Region) && (last_rows <= Region);
    span_x = (last_cols > Region) ? Region - 1 : ((last_cols < 1) ? 1 : last_cols);
    span_y = (last_rows > Region) ? Region - 1 : ((last_rows < 1) ? 1 : last_rows);
    for (int n = 0; n < beats; n++) begin
      if ($urandom_range(0, 99) < 20) begin
        write_cell($urandom_range(0, Region - 2), $urandom_range(0, Region - 2),
                   $urandom_range(0, 99) < 15);
      end else begin
        ang = $urandom_range(0, 62831) / 10000.0;
        if (!far_ok || $urandom_range(0, 9) < 8) begin
          px = $urandom_range(0, span_x * 256 - 1);
          py = $urandom_range(0, span_y * 256 - 1);
        end else begin
          px = $urandom_range(0, 16383);
          py = $urandom_range(0, 16383);
        end
        cast_ray(px, py, rand_dir(1'b1, ang), rand_dir(1'b0, ang),
                 $urandom_range(0, 1023));
      end
    end
  endtask

  initial begin
    item_ch.valid = 1'b0;
    item_ch.data = '0;
    cfg_we_i = 1'b0;
    cfg_idx_i = rgd_pkg::CfgMapColumns;
    cfg_data_i = '0;
    casts_sent = 0;
    writes_sent = 0;
    last_cols = 64;
    last_rows = 64;
    no_idle = 1'b1;
    rst_ni = 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    set_map_size(64, 64);
    // Every cell of the region is written before the first cast, and its
    // closing row and column of walls keep every cast on written cells.
    for (int row = 0; row < Region; row++)
      for (int col = 0; col < Region; col++)
        write_cell(col, row, (row == Region - 1) || (col == Region - 1) ||
                             ($urandom_range(0, 99) < 12));
    no_idle = 1'b0;

    // Directed casts: position and column extremes, zero components (both
    // zero gives a tie that steps along y), overlong and most negative
    // directions, and a wall right next to the start.
    write_cell(1, 0, 1'b1);
    cast_ray(0, 0, 0, 0, 0);
    cast_ray(16383, 16383, 0, 0, 1023);
    cast_ray(16383, 16383, 16384, 16384, 1023);
    cast_ray(0, 0, -16384, -16384, 5);
    cast_ray(0, 0, 16384, 0, 6);
    cast_ray(256, 0, -16384, 0, 7);
    cast_ray(0, 0, -32768, 1, 8);
    cast_ray(3000, 3000, 32767, -32768, 9);
    cast_ray(3000, 3000, 1, -1, 10);
    cast_ray(3000, 3000, -1, 1, 11);
    cast_ray(128, 128, 11585, 11585, 12);
    cast_ray(16255, 100, 0, -16384, 13);
    cast_ray(100, 16255, 3, 16384, 14);
    cast_ray(4200, 4200, -11585, 11585, 15);
    cast_ray(16383, 0, 32767, 32767, 16);

    set_map_size(64, 64);
    random_phase(150);
    set_map_size(1, 1);
    random_phase(60);
    set_map_size(0, 0);
    random_phase(30);
    set_map_size(127, 127);
    random_phase(60);
    no_idle = 1'b1;
    set_map_size(17, 33);
    random_phase(60);
    no_idle = 1'b0;
    set_map_size(64, 1);
    random_phase(50);
    set_map_size(1, 64);
    random_phase(50);
    set_map_size($urandom_range(2, 63), $urandom_range(2, 63));
    random_phase(50);

    item_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (400) @(posedge clk_i);
    $display("Covered %0d casts and %0d cell writes over eight map sizes,", casts_sent,
             writes_sent);
    $display("including empty and oversized maps; %0d columns compared.", columns_checked);
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Watchdog, far beyond the slowest legal run.
  initial begin
    #10ms;
    $display("Timeout with %0d columns outstanding.", pending);
    $display("*** FAILED ***");
    $finish;
  end

endmodule
